// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker; clk and arst_n come from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold while out of reset
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/fdubr_pkg.sv =====
// Shared types and constants for the full duplex UART byte relay.
package fdubr_pkg;

	localparam int FRAME_BITS = 10;
	localparam logic [3:0] LAST_BIT = 4'd9;
	localparam logic [7:0] RESYNC_TIMEOUT_RST = 8'hFD;
	localparam logic [7:0] ERROR_GAP_RST = 8'd2;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESYNC_TIMEOUT = 1'b0,
		REG_ERROR_GAP      = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_FRAME  = 2'd1,
		PH_RESYNC = 2'd2,
		PH_GAP    = 2'd3
	} phase_t;

	// one classified tick from the front end
	typedef struct packed {
		logic       rx;
		logic       fall;
		logic       push_valid;
		logic [7:0] push_byte;
	} tick_t;

	// one result beat
	typedef struct packed {
		logic       tx_level;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       frame_error;
		logic       busy_res;
		logic [6:0] queue_count;
		logic       push_dropped;
	} res_t;

	// tick (counted from frame start) at which frame bit idx is sampled and driven
	function automatic logic [7:0] sample_at(input logic [3:0] idx);
		logic [7:0] t;
		case (idx)
			4'd0: t = 8'd6;
			4'd1: t = 8'd20;
			4'd2: t = 8'd32;
			4'd3: t = 8'd46;
			4'd4: t = 8'd60;
			4'd5: t = 8'd72;
			4'd6: t = 8'd84;
			4'd7: t = 8'd100;
			4'd8: t = 8'd110;
			4'd9: t = 8'd124;
			default: t = 8'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== sv/fdubr_ram.sv =====
// Generic single write port RAM with registered read.
module fdubr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/fdubr_fifo2.sv =====
// Two-entry queue used between stages; full/empty do not depend on the far side.
module fdubr_fifo2 #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;
	logic             wr;
	logic             rd;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[rptr_q];
	assign wr        = in_valid && in_ready;
	assign rd        = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr) begin
				wptr_q <= ~wptr_q;
			end
			if (rd) begin
				rptr_q <= ~rptr_q;
			end
			case ({wr, rd})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wptr_q] <= in_data;
		end
	end

endmodule

// ===== sv/fdubr_front.sv =====
// Front end: takes tick beats, flags the rx falling edge, queues them for the back end.
module fdubr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             rx_level,
	input  logic             push_valid,
	input  logic [7:0]       push_byte,
	output logic             t_valid,
	input  logic             t_ready,
	output fdubr_pkg::tick_t t_data
);
	import fdubr_pkg::*;

	logic  last_rx_q;
	logic  in_ready;
	logic  acc;
	tick_t cls;

	assign full = !in_ready;
	assign acc  = push && in_ready;

	always_comb begin
		cls.rx         = rx_level;
		cls.fall       = last_rx_q && !rx_level;
		cls.push_valid = push_valid;
		cls.push_byte  = push_byte;
	end

	// line idles high, so the first low tick after reset is a falling edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_rx_q <= 1'b1;
		end else if (acc) begin
			last_rx_q <= rx_level;
		end
	end

	fdubr_fifo2 #(
		.WIDTH($bits(tick_t))
	) u_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push),
		.in_ready (in_ready),
		.in_data  (cls),
		.out_valid(t_valid),
		.out_ready(t_ready),
		.out_data (t_data)
	);

endmodule

// ===== sv/fdubr_back.sv =====
// Back end: frame timing, shift registers, byte queue control and config registers.
module fdubr_back #(
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             t_valid,
	output logic                             t_ready,
	input  fdubr_pkg::tick_t                 t,
	output logic                             r_valid,
	input  logic                             r_ready,
	output fdubr_pkg::res_t                  r,
	input  logic                             cfg_we,
	input  logic [fdubr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [7:0]                       cfg_wdata
);
	import fdubr_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// state
	phase_t          phase_q, phase_d;
	logic [7:0]      tick_q, tick_d;
	logic [3:0]      bit_q, bit_d;
	logic [9:0]      out_q, out_d;
	logic [9:0]      in_q, in_d;
	logic            tx_q, tx_d;
	logic [FW-1:0]   fill_q, fill_d;
	logic [AW-1:0]   head_q, head_d;
	logic [AW-1:0]   tail_q, tail_d;
	logic            pend_q;
	logic [AW-1:0]   pend_addr_q;
	logic [7:0]      pend_data_q;
	logic            load_q;
	logic            byp_q;
	logic [7:0]      byp_byte_q;
	logic [7:0]      timeout_q;
	logic [7:0]      gap_q;

	// decisions
	logic            go;
	logic            push1, drop1, push2, drop2;
	logic [FW-1:0]   fill_a, fill_b;
	logic [AW-1:0]   tail_a, tail_b;
	logic [7:0]      tick_inc, tick_sat;
	logic            hit, frame_end, good;
	logic [9:0]      in_hit;
	logic [7:0]      rbyte;
	logic            may_start, start, bypass;
	logic [9:0]      out_cur;

	// RAM port
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr;
	logic [7:0]      ram_wdata, ram_rdata;

	// a pending second write holds back the next beat until it is written
	assign t_ready = r_ready && !pend_q;
	assign go      = t_valid && t_ready;
	assign r_valid = go;

	always_comb begin
		push1  = t.push_valid && (fill_q != FILL_MAX);
		drop1  = t.push_valid && !push1;
		fill_a = fill_q + FW'(push1);
		tail_a = push1 ? ptr_inc(tail_q) : tail_q;

		tick_inc = tick_q + 8'd1;
		tick_sat = (tick_q == 8'hFF) ? tick_q : tick_inc;

		hit       = (phase_q == PH_FRAME) && (tick_inc == sample_at(bit_q));
		frame_end = hit && (bit_q == LAST_BIT);
		for (int i = 0; i < FRAME_BITS; i++) begin
			in_hit[i] = in_q[i] | ((bit_q == 4'(i)) && t.rx);
		end
		good  = in_hit[9] && !in_hit[0];
		rbyte = frame_end ? in_hit[8:1] : 8'h00;

		push2  = frame_end && good && (fill_a != FILL_MAX);
		drop2  = frame_end && good && !push2;
		fill_b = fill_a + FW'(push2);
		tail_b = push2 ? ptr_inc(tail_a) : tail_a;

		case (phase_q)
			PH_IDLE:   may_start = t.fall;
			PH_RESYNC: may_start = !t.rx || (tick_sat >= timeout_q);
			PH_GAP:    may_start = (tick_sat >= gap_q);
			default:   may_start = 1'b0;
		endcase
		start  = go && may_start && (fill_b != '0);
		// queue was empty before this tick: the byte popped is the one just pushed
		bypass = (fill_q == '0);
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (go) begin
			case (phase_q)
				PH_IDLE: begin
					if (start) phase_d = PH_FRAME;
				end
				PH_FRAME: begin
					if (frame_end) phase_d = good ? PH_RESYNC : PH_GAP;
				end
				PH_RESYNC, PH_GAP: begin
					if (may_start) phase_d = start ? PH_FRAME : PH_IDLE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// datapath and result
	always_comb begin
		out_cur = load_q ? {out_q[9], (byp_q ? byp_byte_q : ram_rdata), out_q[0]} : out_q;

		tick_d = tick_q;
		bit_d  = bit_q;
		in_d   = in_q;
		out_d  = out_cur;
		tx_d   = tx_q;
		head_d = head_q;
		tail_d = tail_q;
		fill_d = fill_q;

		if (go) begin
			case (phase_q)
				PH_FRAME: begin
					tick_d = tick_inc;
					if (hit) begin
						tx_d  = out_cur[0];
						out_d = {1'b0, out_cur[9:1]};
						in_d  = in_hit;
						if (frame_end) begin
							tick_d = 8'd0;
							bit_d  = 4'd0;
						end else begin
							bit_d = bit_q + 4'd1;
						end
					end
				end
				PH_RESYNC: begin
					if (t.rx) tick_d = tick_sat;
				end
				PH_GAP: tick_d = tick_sat;
				default: tick_d = tick_q;
			endcase
			if (start) begin
				tick_d = 8'd0;
				bit_d  = 4'd0;
				in_d   = '0;
				// stop and start bits now, data bits land on the next edge
				out_d  = 10'b10_0000_0000;
				head_d = ptr_inc(head_q);
			end
			tail_d = tail_b;
			fill_d = fill_b - FW'(start);
		end

		r.tx_level     = tx_d;
		r.rx_valid     = frame_end && good;
		r.rx_byte      = rbyte;
		r.frame_error  = frame_end && !good;
		r.busy_res     = (phase_d != PH_IDLE);
		r.queue_count  = 7'(fill_d);
		r.push_dropped = drop1 || drop2;

		if (pend_q) begin
			ram_we    = 1'b1;
			ram_waddr = pend_addr_q;
			ram_wdata = pend_data_q;
		end else if (go && push1) begin
			ram_we    = 1'b1;
			ram_waddr = tail_q;
			ram_wdata = t.push_byte;
		end else begin
			ram_we    = go && push2;
			ram_waddr = tail_a;
			ram_wdata = rbyte;
		end
		ram_re = start && !bypass;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= 8'd0;
			bit_q     <= 4'd0;
			out_q     <= '1;
			in_q      <= '0;
			tx_q      <= 1'b1;
			fill_q    <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			pend_q    <= 1'b0;
			load_q    <= 1'b0;
			timeout_q <= RESYNC_TIMEOUT_RST;
			gap_q     <= ERROR_GAP_RST;
		end else begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			out_q   <= out_d;
			in_q    <= in_d;
			tx_q    <= tx_d;
			fill_q  <= fill_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			pend_q  <= go && push1 && push2;
			load_q  <= start;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_RESYNC_TIMEOUT: timeout_q <= cfg_wdata;
					REG_ERROR_GAP:      gap_q     <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && push1 && push2) begin
			pend_addr_q <= tail_a;
			pend_data_q <= rbyte;
		end
		if (start) begin
			byp_q      <= bypass;
			byp_byte_q <= t.push_byte;
		end
	end

	fdubr_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

endmodule

// ===== sv/full_duplex_uart_byte_relay_unit.sv =====
// Top level of the full duplex UART byte relay.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  tick in  | push / full          | rx_level, push_valid, push_byte
//  result   | empty / pop          | tx_level, rx_valid, rx_byte, frame_error,
//           |                      | busy_res, queue_count, push_dropped
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One tick beat in, one result beat out. Throughput is one beat per clock while
// the result queue has room, except that a tick which both queues an offered byte
// and a received byte holds the next tick back while the second byte is written,
// because the byte store has a single write port. The back end works a tick once
// it leaves the front queue, and its result is registered in the result queue.
// Reset is asynchronous; no clearing pass is needed (store entries are only read
// after being written). Either side may stall freely; the two-entry queues keep
// full and empty independent of the far side.
module full_duplex_uart_byte_relay_unit #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// tick channel
	input  logic                              push,
	output logic                              full,
	input  logic                              rx_level,
	input  logic                              push_valid,
	input  logic [7:0]                        push_byte,
	// result channel
	output logic                              empty,
	input  logic                              pop,
	output logic                              tx_level,
	output logic                              rx_valid,
	output logic [7:0]                        rx_byte,
	output logic                              frame_error,
	output logic                              busy_res,
	output logic [6:0]                        queue_count,
	output logic                              push_dropped,
	// config channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fdubr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                        cfg_data
);
	import fdubr_pkg::*;

	tick_t t_data;
	logic  t_valid, t_ready;
	res_t  r_data, r_out;
	logic  r_valid, r_ready;
	logic  o_valid;

	// registers are to change only while idle, which the block does not enforce; the port never pushes back
	assign cfg_ready = 1'b1;

	// front: accept ticks, mark the rx falling edge
	fdubr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_level  (rx_level),
		.push_valid(push_valid),
		.push_byte (push_byte),
		.t_valid   (t_valid),
		.t_ready   (t_ready),
		.t_data    (t_data)
	);

	// back: frame sequencing, byte queue, config registers
	fdubr_back #(
		.DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.t_valid  (t_valid),
		.t_ready  (t_ready),
		.t        (t_data),
		.r_valid  (r_valid),
		.r_ready  (r_ready),
		.r        (r_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_idx  (cfg_index),
		.cfg_wdata(cfg_data)
	);

	// result queue: holds finished beats while the consumer stalls
	fdubr_fifo2 #(
		.WIDTH($bits(res_t))
	) u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (r_valid),
		.in_ready (r_ready),
		.in_data  (r_data),
		.out_valid(o_valid),
		.out_ready(pop),
		.out_data (r_out)
	);

	assign empty        = !o_valid;
	assign tx_level     = r_out.tx_level;
	assign rx_valid     = r_out.rx_valid;
	assign rx_byte      = r_out.rx_byte;
	assign frame_error  = r_out.frame_error;
	assign busy_res     = r_out.busy_res;
	assign queue_count  = r_out.queue_count;
	assign push_dropped = r_out.push_dropped;

endmodule

// ===== sv/fdubr_checker.sv =====
// Port-level checker for the relay, bound to the top level.
`include "assert_macros.svh"

module fdubr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       tx_level,
	input logic       rx_valid,
	input logic [7:0] rx_byte,
	input logic       frame_error,
	input logic       busy_res
);

	// a finished frame is either good or bad, never both
	`ASSERT_NEVER(a_end_kind, !empty && rx_valid && frame_error)

	// the byte field is zero on beats where no frame ends
	`ASSERT_IMPL(a_byte_zero, !empty && !rx_valid && !frame_error, rx_byte == 8'h00)

	// a frame ends on its stop bit and moves to resync wait or gap
	`ASSERT_IMPL(a_end_state, !empty && (rx_valid || frame_error), tx_level && busy_res)

	// an unpopped beat stays put
	`ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(rx_byte) && $stable(tx_level))

endmodule

bind full_duplex_uart_byte_relay_unit fdubr_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.tx_level   (tx_level),
	.rx_valid   (rx_valid),
	.rx_byte    (rx_byte),
	.frame_error(frame_error),
	.busy_res   (busy_res)
);

// ===== tb/relay_checker.sv =====
// Predictor and result checker for the full duplex UART byte relay.
`timescale 1ns / 100ps

module relay_checker #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  logic                          rx_level,
	input  logic                          push_valid,
	input  logic [7:0]                    push_byte,
	input  logic                          empty,
	input  logic                          pop,
	input  logic                          tx_level,
	input  logic                          rx_valid,
	input  logic [7:0]                    rx_byte,
	input  logic                          frame_error,
	input  logic                          busy_res,
	input  logic [6:0]                    queue_count,
	input  logic                          push_dropped,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [fdubr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	output int                            fails,
	output int                            pending
);
	import fdubr_pkg::*;

	// frame tick at which each bit is sampled and driven
	localparam logic [0:9][7:0] BIT_TICK = {8'd6, 8'd20, 8'd32, 8'd46, 8'd60,
		8'd72, 8'd84, 8'd100, 8'd110, 8'd124};

	logic [7:0] resync_limit;
	logic [7:0] gap_limit;

	phase_t     ph;
	logic [7:0] tick;
	logic [3:0] bit_n;
	logic [9:0] tx_shift;
	logic [9:0] rx_shift;
	logic       tx_line;
	logic       prev_rx;
	logic [7:0] tx_store [QUEUE_DEPTH];
	int         head;
	int         tail;
	int         fill;

	res_t awaited_lines[$];

	function automatic bit fifo_put(input logic [7:0] b);
		if (fill >= QUEUE_DEPTH)
			return 1'b0;
		tx_store[tail] = b;
		tail = (tail + 1) % QUEUE_DEPTH;
		fill++;
		return 1'b1;
	endfunction

	function automatic logic [7:0] fifo_take();
		logic [7:0] b;
		b = tx_store[head];
		head = (head + 1) % QUEUE_DEPTH;
		fill--;
		return b;
	endfunction

	task automatic open_frame();
		ph = PH_FRAME;
		tick = 8'd0;
		bit_n = 4'd0;
		tx_shift = {1'b1, fifo_take(), 1'b0};
		rx_shift = '0;
	endtask

	task automatic frame_or_idle();
		if (fill != 0)
			open_frame();
		else
			ph = PH_IDLE;
	endtask

	// one line tick: queue the offered byte, then run the line logic
	task automatic predict_tick(input logic rx, input logic pv, input logic [7:0] pb,
			output res_t r);
		logic       drop;
		logic       good;
		logic       bad;
		logic [7:0] got;
		drop = 1'b0;
		good = 1'b0;
		bad = 1'b0;
		got = 8'h00;
		if (pv && !fifo_put(pb))
			drop = 1'b1;
		case (ph)
			PH_IDLE: begin
				if (prev_rx && !rx && fill != 0)
					open_frame();
			end
			PH_FRAME: begin
				tick = tick + 8'd1;
				if (bit_n < FRAME_BITS && tick == BIT_TICK[bit_n]) begin
					if (rx)
						rx_shift[bit_n] = 1'b1;
					tx_line = tx_shift[0];
					tx_shift = tx_shift >> 1;
					if (bit_n == LAST_BIT) begin
						got = rx_shift[8:1];
						tick = 8'd0;
						bit_n = 4'd0;
						if (rx_shift[9] && !rx_shift[0]) begin
							good = 1'b1;
							if (!fifo_put(got))
								drop = 1'b1;
							ph = PH_RESYNC;
						end else begin
							bad = 1'b1;
							ph = PH_GAP;
						end
					end else begin
						bit_n = bit_n + 4'd1;
					end
				end else if (bit_n >= FRAME_BITS) begin
					bit_n = 4'd0;
					ph = PH_IDLE;
				end
			end
			PH_RESYNC: begin
				if (!rx) begin
					frame_or_idle();
				end else begin
					if (tick != 8'hFF)
						tick = tick + 8'd1;
					if (tick >= resync_limit)
						frame_or_idle();
				end
			end
			default: begin
				if (tick != 8'hFF)
					tick = tick + 8'd1;
				if (tick >= gap_limit)
					frame_or_idle();
			end
		endcase
		prev_rx = rx;
		r.tx_level = tx_line;
		r.rx_valid = good;
		r.rx_byte = got;
		r.frame_error = bad;
		r.busy_res = (ph != PH_IDLE);
		r.queue_count = 7'(fill);
		r.push_dropped = drop;
	endtask

	task automatic check_field(input string what, input logic [7:0] want,
			input logic [7:0] seen);
		if (seen !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want,
				seen);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			resync_limit = RESYNC_TIMEOUT_RST;
			gap_limit = ERROR_GAP_RST;
			ph = PH_IDLE;
			tick = 8'd0;
			bit_n = 4'd0;
			tx_shift = '1;
			rx_shift = '0;
			tx_line = 1'b1;
			prev_rx = 1'b1;
			head = 0;
			tail = 0;
			fill = 0;
			fails = 0;
			awaited_lines.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RESYNC_TIMEOUT: resync_limit = cfg_data;
					REG_ERROR_GAP:      gap_limit = cfg_data;
					default: ;
				endcase
			end
			// results leave only after their tick has been registered, so check first
			if (pop && !empty) begin
				if (awaited_lines.size() == 0) begin
					$display("%0t: result beat with nothing awaited, expected none, actual %0h",
						$time, {tx_level, rx_valid, rx_byte, frame_error, busy_res,
						queue_count, push_dropped});
					fails++;
				end else begin
					want = awaited_lines.pop_front();
					check_field("tx_level", want.tx_level, tx_level);
					check_field("rx_valid", want.rx_valid, rx_valid);
					check_field("rx_byte", want.rx_byte, rx_byte);
					check_field("frame_error", want.frame_error, frame_error);
					check_field("busy_res", want.busy_res, busy_res);
					check_field("queue_count", want.queue_count, queue_count);
					check_field("push_dropped", want.push_dropped, push_dropped);
				end
			end
			if (push && !full) begin
				predict_tick(rx_level, push_valid, push_byte, want);
				awaited_lines.push_back(want);
			end
			pending <= awaited_lines.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top: clock, reset, line stimulus, result pacing and the verdict.
`timescale 1ns / 100ps

module tb;
	import fdubr_pkg::*;

	localparam int QUEUE_DEPTH = 64;
	// ticks per random phase; four phases plus a short directed start
	localparam int PHASE_TICKS = 420;
	localparam int NUM_PHASES = 4;
	// worst case per tick is a long sender gap plus a long result stall;
	// the limit covers that several times over for ~2000 ticks
	localparam int CYCLE_LIMIT = 800_000;
	// front queue, back end, result queue
	localparam int PIPE_DEPTH = 3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       rx_level = 1'b1;
	logic       push_valid = 1'b0;
	logic [7:0] push_byte = 8'h00;
	logic       pop = 1'b0;
	logic       cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = 8'h00;

	logic       full;
	logic       empty;
	logic       tx_level;
	logic       rx_valid;
	logic [7:0] rx_byte;
	logic       frame_error;
	logic       busy_res;
	logic [6:0] queue_count;
	logic       push_dropped;
	logic       cfg_ready;

	int check_fails;
	int check_pending;

	int  cycle = 0;
	int  ticks_sent = 0;
	int  stall_left = 0;
	bit  src_steady = 1'b0;
	bit  sink_steady = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	full_duplex_uart_byte_relay_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_level(rx_level),
		.push_valid(push_valid),
		.push_byte(push_byte),
		.empty(empty),
		.pop(pop),
		.tx_level(tx_level),
		.rx_valid(rx_valid),
		.rx_byte(rx_byte),
		.frame_error(frame_error),
		.busy_res(busy_res),
		.queue_count(queue_count),
		.push_dropped(push_dropped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	relay_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_level(rx_level),
		.push_valid(push_valid),
		.push_byte(push_byte),
		.empty(empty),
		.pop(pop),
		.tx_level(tx_level),
		.rx_valid(rx_valid),
		.rx_byte(rx_byte),
		.frame_error(frame_error),
		.busy_res(busy_res),
		.queue_count(queue_count),
		.push_dropped(push_dropped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fails(check_fails),
		.pending(check_pending)
	);

	// run limit; a hang anywhere ends here
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side pacing: mostly ready, short stalls, now and then a long one,
	// with stretches of no stalls at all
	always @(posedge clk) begin : sink_pace
		int r;
		r = $urandom_range(99);
		if (stall_left != 0) begin
			pop <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			pop <= 1'b1;
			if (!sink_steady) begin
				if (r < 3)
					stall_left <= $urandom_range(40, 10);
				else if (r < 30)
					stall_left <= $urandom_range(3, 1);
			end
		end
		if (cycle % 300 == 0)
			sink_steady <= ($urandom_range(3) == 0);
	end

	// one tick beat, with an optional random gap ahead of it; push stays high
	// across back-to-back beats
	task automatic send_tick(input logic rx, input logic pv, input logic [7:0] b);
		int gap;
		int r;
		gap = 0;
		r = $urandom_range(99);
		if (!src_steady) begin
			if (r < 3)
				gap = $urandom_range(40, 10);
			else if (r < 25)
				gap = $urandom_range(3, 1);
		end
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx_level <= rx;
		push_valid <= pv;
		push_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		ticks_sent++;
	endtask

	// hold off until every predicted result beat has been popped
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (check_pending != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 1) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// line held high, optional queue traffic
	task automatic send_idle(input int n, input int push_pct);
		repeat (n)
			send_tick(1'b1, $urandom_range(99) < push_pct, 8'($urandom));
	endtask

	// An 8N1 frame laid on the block's sampling timetable: tick 0 is the
	// falling edge, bit i holds until its sample tick. A broken start goes
	// low just long enough to trigger the edge, then high before the sample.
	task automatic send_frame(input logic [7:0] data, input bit bad_start, input bit bad_stop,
			input int push_pct);
		logic [9:0] bits;
		int         idx;
		logic       lvl;
		bits = {~bad_stop, data, 1'b0};
		idx = 0;
		for (int t = 0; t <= int'(sample_at(LAST_BIT)); t++) begin
			if (t > int'(sample_at(4'(idx))))
				idx++;
			lvl = bits[idx];
			if (bad_start && idx == 0 && t >= 3)
				lvl = 1'b1;
			send_tick(lvl, $urandom_range(99) < push_pct, 8'($urandom));
		end
	endtask

	// raw line noise
	task automatic send_noise(input int n);
		repeat (n)
			send_tick(1'($urandom), $urandom_range(3) == 0, 8'($urandom));
	endtask

	initial begin : stimulus
		int phase_end;
		int pick;
		int pct;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed start, reset settings.
		// falling edge with an empty queue: block stays idle
		send_tick(1'b0, 1'b0, 8'h00);
		send_tick(1'b1, 1'b0, 8'h00);
		// byte offered on the falling edge: queued and popped in the same tick
		send_tick(1'b0, 1'b1, 8'h00);
		// queue traffic while the frame runs, byte extremes and alternating bits
		send_tick(1'b0, 1'b1, 8'hFF);
		send_tick(1'b0, 1'b1, 8'h55);
		send_tick(1'b1, 1'b1, 8'hAA);
		send_tick(1'b1, 1'b1, 8'h80);
		send_tick(1'b1, 1'b1, 8'h01);
		send_tick(1'b0, 1'b0, 8'hFF);
		send_tick(1'b1, 1'b0, 8'h00);

		// Random phases, each under its own register setting. Mostly clean
		// frames with random data, some with broken start or stop, plus
		// noise, queue-filling bursts and idle line stretches.
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p != 0) begin
				drain();
				case (p)
					1: begin
						write_reg(REG_RESYNC_TIMEOUT, 8'd0);
						write_reg(REG_ERROR_GAP, 8'd0);
					end
					2: begin
						write_reg(REG_RESYNC_TIMEOUT, 8'd255);
						write_reg(REG_ERROR_GAP, 8'd255);
					end
					default: begin
						write_reg(REG_RESYNC_TIMEOUT, 8'($urandom_range(60, 1)));
						write_reg(REG_ERROR_GAP, 8'($urandom_range(20, 1)));
					end
				endcase
			end
			phase_end = ticks_sent + PHASE_TICKS;
			while (ticks_sent < phase_end) begin
				src_steady = ($urandom_range(3) == 0);
				pick = $urandom_range(99);
				case ($urandom_range(2))
					0: pct = 0;
					1: pct = 5;
					default: pct = 40;
				endcase
				if (pick < 70) begin
					send_frame(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0,
						pct);
					send_idle($urandom_range(12), pct);
				end else if (pick < 80) begin
					send_noise($urandom_range(60, 5));
				end else if (pick < 88) begin
					// fill the queue toward full so offered bytes get dropped
					send_idle($urandom_range(80, 20), 90);
				end else if (pick < 96) begin
					send_idle($urandom_range(40, 1), pct);
				end else begin
					// long enough to run past most resync timeouts
					send_idle($urandom_range(300, 100), 0);
				end
				if ($urandom_range(19) == 0)
					drain();
			end
		end

		drain();
		if (check_fails == 0 && check_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/fdubr_pkg.sv
sv/fdubr_ram.sv
sv/fdubr_fifo2.sv
sv/fdubr_front.sv
sv/fdubr_back.sv
sv/full_duplex_uart_byte_relay_unit.sv
sv/fdubr_checker.sv
tb/relay_checker.sv
tb/tb.sv
